@@ rtl/mpmc_pkg.sv @@
`timescale 1ns / 1ps
package mpmc_pkg;

  localparam int OP_W          = 2;
  localparam int LETTER_W      = 5;
  localparam int TOTAL_W       = 32;
  localparam int HITS_W        = 16;
  localparam int MAX_NODES_DEF = 1024;
  localparam int ALPHA_DEF     = 26;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR,
    OP_PATTERN,
    OP_BUILD,
    OP_TEXT
  } op_e;

  // which node row the goto memory reads this cycle
  typedef enum logic [1:0] {
    RS_SCAN,
    RS_CUR,
    RS_QDATA,
    RS_FAIL
  } rsel_e;

  typedef struct packed {
    logic  latch;
    logic  clear;
    rsel_e rsel;
    logic  pat_take;
    logic  pat_ovf;
    logic  pat_link;
    logic  pat_new;
    logic  pat_hit;
    logic  txt_out;
    logic  b_init;
    logic  b_x;
    logic  b_f;
    logic  b_f2;
    logic  b_rd;
    logic  b_fill;
    logic  b_c;
    logic  b_wb;
    logic  b_done;
    logic  t_inc;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic letter_ok;
    logic built;
    logic fin;
    logic child_zero;
    logic full;
    logic out_busy;
    logic q_more;
    logic c_zero;
    logic t_last;
  } status_t;

  function automatic logic [HITS_W-1:0] hits_sat(input logic [HITS_W-1:0] a,
                                                 input logic [HITS_W-1:0] b);
    logic [HITS_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[HITS_W] ? '1 : s[HITS_W-1:0];
  endfunction

endpackage

@@ rtl/mpmc_in_if.sv @@
`timescale 1ns / 1ps
interface mpmc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [4:0] letter;
  logic       final_letter;

  modport source (output valid, output op, output letter, output final_letter, input ready);
  modport sink (input valid, input op, input letter, input final_letter, output ready);
endinterface

@@ rtl/mpmc_out_if.sv @@
`timescale 1ns / 1ps
interface mpmc_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] match_total;
  logic        text_end;
  logic        table_full;

  modport source (output valid, output match_total, output text_end, output table_full,
                  input ready);
  modport sink (input valid, input match_total, input text_end, input table_full,
                output ready);
endinterface

@@ rtl/mpmc_dpath.sv @@
`timescale 1ns / 1ps
module mpmc_dpath import mpmc_pkg::*; #(
  parameter int MaxNodes  = MAX_NODES_DEF,
  parameter int AlphaSize = ALPHA_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  input  logic [OP_W-1:0]     op_i,
  input  logic [LETTER_W-1:0] letter_i,
  input  logic                final_letter_i,
  mpmc_out_if.source          out_o
);

  localparam int NW = $clog2(MaxNodes);
  localparam int AW = $clog2(AlphaSize);

  typedef logic [AlphaSize-1:0][NW-1:0] row_t;

  row_t              goto_mem  [MaxNodes];
  logic [HITS_W-1:0] hits_mem  [MaxNodes];
  logic [NW-1:0]     fail_mem  [MaxNodes];
  logic [NW-1:0]     queue_mem [MaxNodes];

  logic [LETTER_W-1:0] letter_q;
  logic                fin_q;
  row_t                goto_row_q, rowx_q, rowf_q;
  logic [HITS_W-1:0]   hits_a_q, hits_b_q;
  logic [NW-1:0]       fail_rd_q, q_rd_q, x_q, child_q;
  logic [NW-1:0]       cursor_q, scan_q;
  logic [NW:0]         nodes_q, head_q, tail_q;
  logic [AW-1:0]       tcnt_q;
  logic [TOTAL_W-1:0]  total_q;
  logic                built_q, ovf_q;
  logic                out_valid_q, text_end_q, table_full_q;
  logic [TOTAL_W-1:0]  match_q;

  logic [AW-1:0]        col;
  logic [NW-1:0]        child, c, via, g_raddr, g_waddr, ha_addr, h_waddr;
  logic [AlphaSize-1:0] g_wen;
  row_t                 g_wrow;
  logic                 h_we;
  logic [HITS_W-1:0]    h_wdata;
  logic [TOTAL_W:0]     sum_w;
  logic [TOTAL_W-1:0]   sum;
  logic                 tail_room;

  assign col       = AW'(letter_q);
  assign child     = goto_row_q[col];
  assign c         = rowx_q[tcnt_q];
  assign via       = (x_q == '0) ? '0 : rowf_q[tcnt_q];
  assign ha_addr   = cmd_i.b_rd ? c : child;
  assign tail_room = tail_q < (NW+1)'(MaxNodes);
  assign sum_w     = {1'b0, total_q} + (TOTAL_W+1)'(hits_a_q);
  assign sum       = sum_w[TOTAL_W] ? '1 : sum_w[TOTAL_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      letter_q <= letter_i;
      fin_q    <= final_letter_i;
    end
  end

  // goto memory: whole node row read, per-letter write enables
  always_comb begin
    unique case (cmd_i.rsel)
      RS_SCAN:  g_raddr = scan_q;
      RS_CUR:   g_raddr = cursor_q;
      RS_QDATA: g_raddr = q_rd_q;
      RS_FAIL:  g_raddr = fail_rd_q;
      default:  g_raddr = scan_q;
    endcase
  end

  always_comb begin
    g_wen   = '0;
    g_waddr = cursor_q;
    g_wrow  = '0;
    priority if (cmd_i.clear) begin
      g_wen   = '1;
      g_waddr = '0;
    end else if (cmd_i.pat_link) begin
      g_wen  = AlphaSize'(1) << col;
      g_wrow = {AlphaSize{nodes_q[NW-1:0]}};
    end else if (cmd_i.pat_new) begin
      g_wen   = '1;
      g_waddr = nodes_q[NW-1:0];
    end else if (cmd_i.b_wb) begin
      g_wen   = '1;
      g_waddr = x_q;
      g_wrow  = rowx_q;
    end
  end

  always_ff @(posedge clk_i) begin
    goto_row_q <= goto_mem[g_raddr];
    for (int k = 0; k < AlphaSize; k++) begin
      if (g_wen[k]) goto_mem[g_waddr][k] <= g_wrow[k];
    end
  end

  always_comb begin
    h_we    = 1'b1;
    h_waddr = '0;
    h_wdata = '0;
    priority if (cmd_i.clear) begin
      h_waddr = '0;
    end else if (cmd_i.pat_new) begin
      h_waddr = nodes_q[NW-1:0];
      h_wdata = HITS_W'(fin_q);
    end else if (cmd_i.pat_hit) begin
      h_waddr = child_q;
      h_wdata = hits_sat(hits_a_q, HITS_W'(1));
    end else if (cmd_i.b_c) begin
      h_waddr = c;
      h_wdata = hits_sat(hits_a_q, hits_b_q);
    end else begin
      h_we = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    hits_a_q <= hits_mem[ha_addr];
    hits_b_q <= hits_mem[via];
    if (h_we) hits_mem[h_waddr] <= h_wdata;
  end

  always_ff @(posedge clk_i) begin
    fail_rd_q <= fail_mem[q_rd_q];
    if (cmd_i.b_c) fail_mem[c] <= via;
  end

  always_ff @(posedge clk_i) begin
    q_rd_q <= queue_mem[head_q[NW-1:0]];
    if (cmd_i.b_init) begin
      queue_mem[0] <= '0;
    end else if (cmd_i.b_c && tail_room) begin
      queue_mem[tail_q[NW-1:0]] <= c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.pat_take) child_q <= child;
    if (cmd_i.b_x) x_q <= q_rd_q;
    if (cmd_i.b_f) rowx_q <= goto_row_q;
    else if (cmd_i.b_fill) rowx_q[tcnt_q] <= via;
    if (cmd_i.b_f2) rowf_q <= goto_row_q;
    if (cmd_i.txt_out) begin
      match_q      <= sum;
      text_end_q   <= fin_q;
      table_full_q <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nodes_q     <= (NW+1)'(1);
      cursor_q    <= '0;
      scan_q      <= '0;
      total_q     <= '0;
      built_q     <= 1'b0;
      ovf_q       <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      tcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        nodes_q  <= (NW+1)'(1);
        cursor_q <= '0;
        scan_q   <= '0;
        total_q  <= '0;
        built_q  <= 1'b0;
        ovf_q    <= 1'b0;
      end
      if (cmd_i.pat_take && !fin_q) cursor_q <= child;
      if (cmd_i.pat_ovf) begin
        ovf_q <= 1'b1;
        if (fin_q) cursor_q <= '0;
      end
      if (cmd_i.pat_new) begin
        cursor_q <= fin_q ? '0 : nodes_q[NW-1:0];
        nodes_q  <= nodes_q + 1'b1;
      end
      if (cmd_i.pat_hit) cursor_q <= '0;
      // scan node moves only with the result (or is zeroed by clear and build) so a stalled beat keeps its row
      if (cmd_i.txt_out) begin
        total_q <= fin_q ? '0 : sum;
        scan_q  <= fin_q ? '0 : child;
      end
      if (cmd_i.b_init) begin
        head_q <= '0;
        tail_q <= (NW+1)'(1);
      end
      if (cmd_i.b_f) tcnt_q <= '0;
      else if (cmd_i.t_inc) tcnt_q <= tcnt_q + 1'b1;
      if (cmd_i.b_c && tail_room) tail_q <= tail_q + 1'b1;
      if (cmd_i.b_wb) head_q <= head_q + 1'b1;
      if (cmd_i.b_done) begin
        built_q <= 1'b1;
        scan_q  <= '0;
        total_q <= '0;
      end
      if (cmd_i.txt_out) out_valid_q <= 1'b1;
      else if (out_o.ready) out_valid_q <= 1'b0;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.match_total = match_q;
  assign out_o.text_end    = text_end_q;
  assign out_o.table_full  = table_full_q;

  assign status_o.op         = op_e'(op_i);
  assign status_o.letter_ok  = int'(letter_i) < AlphaSize;
  assign status_o.built      = built_q;
  assign status_o.fin        = fin_q;
  assign status_o.child_zero = (child == '0);
  assign status_o.full       = (nodes_q == (NW+1)'(MaxNodes));
  assign status_o.out_busy   = out_valid_q && !out_o.ready;
  assign status_o.q_more     = head_q < tail_q;
  assign status_o.c_zero     = (c == '0);
  assign status_o.t_last     = (tcnt_q == AW'(AlphaSize-1));

  a_nodes_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nodes_q >= (NW+1)'(1) && nodes_q <= (NW+1)'(MaxNodes))
    else $error("node count out of range");

  a_cursor_alloc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, cursor_q} < nodes_q)
    else $error("pattern cursor beyond allocated nodes");

  a_queue_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q && tail_q <= (NW+1)'(MaxNodes))
    else $error("walk queue pointers inconsistent");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.txt_out |=> out_valid_q)
    else $error("text result not presented");

endmodule

@@ rtl/mpmc_ctrl.sv @@
`timescale 1ns / 1ps
module mpmc_ctrl import mpmc_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_P_RD, S_P_DEC, S_P_NEW, S_P_HIT, S_T_HIT, S_T_OUT,
    S_B_INIT, S_B_POP, S_B_X, S_B_F, S_B_F2, S_B_T, S_B_C, S_B_WB
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o      = '0;
    cmd_o.rsel = RS_SCAN;
    state_d    = state_q;
    unique case (state_q)
      S_INIT: begin
        cmd_o.clear = 1'b1;
        state_d     = S_IDLE;
      end
      S_IDLE: begin
        cmd_o.latch = in_valid_i;
        if (in_valid_i) begin
          unique case (status_i.op)
            OP_CLEAR:   cmd_o.clear = 1'b1;
            OP_PATTERN: if (status_i.letter_ok && !status_i.built) state_d = S_P_RD;
            OP_BUILD:   if (!status_i.built) state_d = S_B_INIT;
            OP_TEXT:    if (status_i.letter_ok) state_d = S_T_HIT;
            default:    state_d = S_IDLE;
          endcase
        end
      end
      S_P_RD: begin
        cmd_o.rsel = RS_CUR;
        state_d    = S_P_DEC;
      end
      S_P_DEC: begin
        priority if (!status_i.child_zero) begin
          cmd_o.pat_take = 1'b1;
          state_d        = status_i.fin ? S_P_HIT : S_IDLE;
        end else if (status_i.full) begin
          cmd_o.pat_ovf = 1'b1;
          state_d       = S_IDLE;
        end else begin
          cmd_o.pat_link = 1'b1;
          state_d        = S_P_NEW;
        end
      end
      S_P_NEW: begin
        cmd_o.pat_new = 1'b1;
        state_d       = S_IDLE;
      end
      S_P_HIT: begin
        cmd_o.pat_hit = 1'b1;
        state_d       = S_IDLE;
      end
      S_T_HIT: begin
        state_d = S_T_OUT;
      end
      S_T_OUT: begin
        // hold until the output register is free
        if (!status_i.out_busy) begin
          cmd_o.txt_out = 1'b1;
          state_d       = S_IDLE;
        end
      end
      S_B_INIT: begin
        cmd_o.b_init = 1'b1;
        state_d      = S_B_POP;
      end
      S_B_POP: begin
        if (status_i.q_more) begin
          state_d = S_B_X;
        end else begin
          cmd_o.b_done = 1'b1;
          state_d      = S_IDLE;
        end
      end
      S_B_X: begin
        cmd_o.b_x  = 1'b1;
        cmd_o.rsel = RS_QDATA;
        state_d    = S_B_F;
      end
      S_B_F: begin
        cmd_o.b_f  = 1'b1;
        cmd_o.rsel = RS_FAIL;
        state_d    = S_B_F2;
      end
      S_B_F2: begin
        cmd_o.b_f2 = 1'b1;
        state_d    = S_B_T;
      end
      S_B_T: begin
        if (status_i.c_zero) begin
          cmd_o.b_fill = 1'b1;
          cmd_o.t_inc  = !status_i.t_last;
          state_d      = status_i.t_last ? S_B_WB : S_B_T;
        end else begin
          cmd_o.b_rd = 1'b1;
          state_d    = S_B_C;
        end
      end
      S_B_C: begin
        cmd_o.b_c   = 1'b1;
        cmd_o.t_inc = !status_i.t_last;
        state_d     = status_i.t_last ? S_B_WB : S_B_T;
      end
      S_B_WB: begin
        cmd_o.b_wb = 1'b1;
        state_d    = S_B_POP;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/multi_pattern_match_counter_unit.sv @@
`timescale 1ns / 1ps
// text letter: goto row read, hit count read, then sum, held while the output is busy
// pattern letter: goto row read and decode, then a new node or a hit update if needed
// build: node pop, queue and row reads, writeback; per letter a scan and any child update
// text letters are not overlapped: each next node lookup depends on the last one
// after reset the root row is zeroed before the first item is taken
module multi_pattern_match_counter_unit import mpmc_pkg::*; #(
  parameter int MaxNodes  = MAX_NODES_DEF,
  parameter int AlphaSize = ALPHA_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  mpmc_in_if.sink    in_i,
  mpmc_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  logic    ready;

  assign in_i.ready = ready;

  mpmc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  mpmc_dpath #(
    .MaxNodes  (MaxNodes),
    .AlphaSize (AlphaSize)
  ) u_dpath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .op_i           (in_i.op),
    .letter_i       (in_i.letter),
    .final_letter_i (in_i.final_letter),
    .out_o          (out_o)
  );

endmodule

@@ sim/multi_pattern_match_counter_unit_tb.sv @@
`timescale 1ns / 1ps
module multi_pattern_match_counter_unit_tb;
  import mpmc_pkg::*;

  localparam int NODES     = MAX_NODES_DEF;
  localparam int ALPHA     = ALPHA_DEF;
  localparam int CYC_LIMIT = 900000;

  typedef struct packed {
    logic [TOTAL_W-1:0] total;
    logic               last;
    logic               full;
  } match_res_t;

  class match_scoreboard;
    logic [9:0]        next_node [NODES*ALPHA];
    logic [9:0]        fail_of [NODES];
    logic [HITS_W-1:0] hits [NODES];
    logic [9:0]        walk_q [NODES];
    int unsigned       used;
    logic [9:0]        cursor;
    logic [9:0]        scan;
    logic [TOTAL_W-1:0] total;
    logic              built;
    logic              full;
    match_res_t        pending[$];
    int                errors;

    function new();
      errors = 0;
      wipe();
    endfunction

    function void report(string what);
      $display("mismatch: %s", what);
      errors++;
    endfunction

    function void wipe();
      foreach (next_node[i]) next_node[i] = '0;
      foreach (fail_of[i]) fail_of[i] = '0;
      foreach (hits[i]) hits[i] = '0;
      foreach (walk_q[i]) walk_q[i] = '0;
      used = 1;
      cursor = '0;
      scan = '0;
      total = '0;
      built = 1'b0;
      full = 1'b0;
    endfunction

    function logic [HITS_W-1:0] add_hits(logic [HITS_W-1:0] a, logic [HITS_W-1:0] b);
      logic [HITS_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[HITS_W] ? '1 : s[HITS_W-1:0];
    endfunction

    function void grow(logic [4:0] l, logic f);
      int slot;
      logic [9:0] nxt;
      slot = int'(cursor) * ALPHA + int'(l);
      nxt = next_node[slot];
      if (nxt == 0) begin
        if (used >= NODES) begin
          full = 1'b1;
          if (f) cursor = '0;
          return;
        end
        nxt = used[9:0];
        used++;
        next_node[slot] = nxt;
      end
      if (f) begin
        hits[nxt] = add_hits(hits[nxt], 1);
        cursor = '0;
      end else begin
        cursor = nxt;
      end
    endfunction

    // breadth-first walk: failure links, full goto rows, hit counts folded in
    function void link_all();
      int head, tail, slot;
      logic [9:0] x, c, via;
      head = 0;
      tail = 0;
      fail_of[0] = '0;
      walk_q[tail++] = '0;
      while (head < tail && head < NODES) begin
        x = walk_q[head++];
        for (int t = 0; t < ALPHA; t++) begin
          slot = int'(x) * ALPHA + t;
          c = next_node[slot];
          via = (x == 0) ? '0 : next_node[int'(fail_of[x]) * ALPHA + t];
          if (c != 0) begin
            fail_of[c] = via;
            hits[c] = add_hits(hits[c], hits[via]);
            if (tail < NODES) walk_q[tail++] = c;
          end else begin
            next_node[slot] = via;
          end
        end
      end
      built = 1'b1;
      scan = '0;
      total = '0;
    endfunction

    function void note(op_e op, logic [4:0] l, logic f);
      logic [9:0] nxt;
      logic [TOTAL_W:0] s;
      match_res_t r;
      case (op)
        OP_CLEAR: wipe();
        OP_BUILD: if (!built) link_all();
        OP_PATTERN: if (l < ALPHA && !built) grow(l, f);
        OP_TEXT: if (l < ALPHA) begin
          nxt = next_node[int'(scan) * ALPHA + int'(l)];
          s = {1'b0, total} + {17'b0, hits[nxt]};
          total = s[TOTAL_W] ? '1 : s[TOTAL_W-1:0];
          scan = nxt;
          r.total = total;
          r.last = f;
          r.full = full;
          pending.insert(pending.size(), r);
          if (f) begin
            total = '0;
            scan = '0;
          end
        end
        default: ;
      endcase
    endfunction

    function void check(logic [TOTAL_W-1:0] t, logic e, logic fl);
      match_res_t r;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result total=%0d", t));
        return;
      end
      r = pending.pop_front();
      if (t !== r.total) report($sformatf("match_total %0d, wanted %0d", t, r.total));
      if (e !== r.last) report($sformatf("text_end %0b, wanted %0b", e, r.last));
      if (fl !== r.full) report($sformatf("table_full %0b, wanted %0b", fl, r.full));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  mpmc_in_if  in_if ();
  mpmc_out_if out_if ();

  multi_pattern_match_counter_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  match_scoreboard sb = new();

  int burst_left = 0;
  int results_seen = 0;
  int hold_cycles = 0;
  bit hold_done = 1'b0;
  int cycles = 0;

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = OP_CLEAR;
    in_if.letter = '0;
    in_if.final_letter = 1'b0;
    out_if.ready = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYC_LIMIT) begin
      $display("multi_pattern_match_counter_unit_tb failed");
      $finish;
    end
  end

  // receiver: stall pattern rotates through four modes, plus one long hold-off
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        sb.check(out_if.match_total, out_if.text_end, out_if.table_full);
        results_seen <= results_seen + 1;
        if (results_seen == 100 && !hold_done) begin
          hold_cycles <= 600;
          hold_done <= 1'b1;
        end
      end
      if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_if.ready <= 1'b0;
      end else begin
        case ((cycles / 64) % 4)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= cycles[0];
          2: out_if.ready <= ($urandom_range(0, 9) < 7);
          default: out_if.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic put_beat(op_e op, logic [4:0] l, logic f);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.letter <= l;
    in_if.final_letter <= f;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note(op, l, f);
    burst_left--;
  endtask

  function automatic logic [4:0] pick_letter(int span);
    if ($urandom_range(0, 39) == 0) return 5'($urandom_range(ALPHA, 31));
    return 5'($urandom_range(0, span - 1));
  endfunction

  task automatic put_word(op_e op, int len, int span);
    for (int i = 0; i < len; i++) put_beat(op, pick_letter(span), i == len - 1);
  endtask

  initial begin
    int rounds;
    @(posedge rst_ni);
    @(posedge clk_i);
    // directed
    put_beat(OP_CLEAR, 5'd0, 1'b0);
    put_beat(OP_PATTERN, 5'd0, 1'b1);
    put_beat(OP_TEXT, 5'd0, 1'b0);
    put_beat(OP_TEXT, 5'd1, 1'b0);
    put_beat(OP_TEXT, 5'd0, 1'b1);
    put_beat(OP_PATTERN, 5'd0, 1'b0);
    put_beat(OP_PATTERN, 5'd25, 1'b1);
    put_beat(OP_PATTERN, 5'd31, 1'b1);
    put_beat(OP_TEXT, 5'd27, 1'b1);
    put_beat(OP_BUILD, 5'd31, 1'b1);
    put_beat(OP_BUILD, 5'd0, 1'b0);
    put_beat(OP_PATTERN, 5'd25, 1'b1);
    put_beat(OP_TEXT, 5'd25, 1'b0);
    put_beat(OP_TEXT, 5'd0, 1'b0);
    put_beat(OP_TEXT, 5'd25, 1'b0);
    put_beat(OP_TEXT, 5'd0, 1'b1);
    put_beat(OP_TEXT, 5'd30, 1'b0);
    put_beat(OP_CLEAR, 5'd31, 1'b1);
    put_beat(OP_TEXT, 5'd3, 1'b1);

    // random rounds, mostly over small alphabets, so patterns overlap in the text
    rounds = 0;
    while (rounds < 12) begin
      int span;
      span = ($urandom_range(0, 4) == 0) ? ALPHA : $urandom_range(2, 4);
      put_beat(OP_CLEAR, 5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      repeat ($urandom_range(1, 8)) put_word(OP_PATTERN, $urandom_range(1, 4), span);
      if ($urandom_range(0, 9) != 0) put_beat(OP_BUILD, 5'($urandom_range(0, 31)), 1'b0);
      repeat ($urandom_range(1, 4)) begin
        put_word(OP_TEXT, $urandom_range(1, 12), span);
        if ($urandom_range(0, 7) == 0) put_beat(OP_PATTERN, pick_letter(span), 1'b1);
        if ($urandom_range(0, 7) == 0) put_beat(OP_BUILD, 5'd0, 1'b0);
      end
      rounds++;
    end

    // overflow: grow past the node table with long random patterns
    put_beat(OP_CLEAR, 5'd0, 1'b0);
    while (sb.used < NODES) put_word(OP_PATTERN, $urandom_range(8, 16), ALPHA);
    repeat (20) put_word(OP_PATTERN, $urandom_range(2, 5), ALPHA);
    put_word(OP_TEXT, 10, ALPHA);
    put_beat(OP_BUILD, 5'd0, 1'b0);
    repeat (12) put_word(OP_TEXT, $urandom_range(1, 15), ALPHA);
    put_beat(OP_CLEAR, 5'd0, 1'b0);
    put_beat(OP_PATTERN, 5'd2, 1'b1);
    put_word(OP_TEXT, 6, 3);
    in_if.valid <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("multi_pattern_match_counter_unit_tb passed");
    end else begin
      $display("multi_pattern_match_counter_unit_tb failed");
    end
    $finish;
  end

endmodule
